// ===== src/rdbm_pkg.sv =====
// Package for the byte-range DFA matcher: commands, field widths, queue entry type.
// Used by every module of the matcher.
package rdbm_pkg;
  localparam int NumStatesDef = 64;
  localparam int SlotsDef     = 8;
  localparam int PosWidthDef  = 16;
  localparam int StateW       = 6;
  localparam int SlotW        = 3;
  localparam int ByteW        = 8;
  localparam int OutPosW      = 16;
  localparam int CfgIdxW      = 1;
  localparam logic [1:0] CMD_LOAD_SLOT = 2'd0;
  localparam logic [1:0] CMD_LOAD_ATTR = 2'd1;
  localparam logic [1:0] CMD_START     = 2'd2;
  localparam logic [1:0] CMD_DATA      = 2'd3;
  localparam logic [CfgIdxW-1:0] REG_ENTRY = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ERROR = 1'd1;

  // Last member sits in the lowest bits, matching the in_tdata layout.
  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [15:0]       start_position;
    logic [StateW-1:0] fallback_state;
    logic              accepting_flag;
    logic [StateW-1:0] target_state;
    logic [ByteW-1:0]  range_high;
    logic [ByteW-1:0]  range_low;
    logic [SlotW-1:0]  slot_index;
    logic [StateW-1:0] state_index;
    logic [1:0]        command;
  } item_t;
endpackage

// ===== src/rdbm_front.sv =====
// Front end: accepts input transfers and queues them for the engine.
// Two-entry FIFO between the stream slave and the execution engine. Uses rdbm_pkg.
module rdbm_front
  import rdbm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);
  item_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule

// ===== src/rdbm_back.sv =====
// Back end: table memories, DFA step sequencer and result register.
// Data byte: row read into a register, then compare and update in ST_EVAL. Uses rdbm_pkg.
module rdbm_back
  import rdbm_pkg::*;
#(
  parameter int NUM_STATES      = NumStatesDef,
  parameter int SLOTS_PER_STATE = SlotsDef,
  parameter int POSITION_WIDTH  = PosWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  item_t               q_item,
  input  logic [StateW-1:0]   entry_state,
  input  logic [StateW-1:0]   error_state,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_matched,
  output logic [OutPosW-1:0]  out_end_position
);
  localparam int RowW  = ($clog2(NUM_STATES) < StateW) ? $clog2(NUM_STATES) : StateW;
  localparam int EntW  = 2 * ByteW + StateW;
  localparam int AttrW = 1 + StateW;
  localparam logic [POSITION_WIDTH-1:0] PosMax = '1;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;

  logic [SLOTS_PER_STATE*EntW-1:0] row_mem [NUM_STATES];
  logic [AttrW-1:0]                attr_mem [NUM_STATES];
  logic [SLOTS_PER_STATE*EntW-1:0] row_q_r;
  logic [AttrW-1:0]                attr_q_r;
  logic [SLOTS_PER_STATE-1:0]      slot_we;

  logic [1:0]                st_r, st_nxt;
  logic [StateW-1:0]         cur_r, cur_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                      act_r, act_nxt;
  logic [ByteW-1:0]          byte_r;
  logic                      inrow_r;
  logic                      ov_r, ov_nxt, om_r, om_nxt;
  logic [OutPosW-1:0]        op_r, op_nxt;

  logic                      take, sidx_ok, slot_ok, cur_ok;
  logic                      hit;
  logic [StateW-1:0]         hit_tg, nxt_s;
  logic [POSITION_WIDTH-1:0] pos_adv, sp_clamped;
  logic                      emit;
  logic                      emit_m;
  logic [POSITION_WIDTH-1:0] emit_p;

  assign q_ready = (st_r == ST_IDLE) && !ov_r;
  assign take    = q_valid && q_ready;
  assign sidx_ok = ({26'd0, q_item.state_index} < 32'(NUM_STATES));
  assign slot_ok = ({29'd0, q_item.slot_index} < 32'(SLOTS_PER_STATE));
  assign cur_ok  = ({26'd0, cur_r} < 32'(NUM_STATES));

  always_comb begin
    for (int k = 0; k < SLOTS_PER_STATE; k++) begin
      slot_we[k] = take && q_item.command == CMD_LOAD_SLOT && sidx_ok && slot_ok &&
                   (32'(q_item.slot_index) == k);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOTS_PER_STATE; k++) begin
      if (slot_we[k]) begin
        row_mem[q_item.state_index[RowW-1:0]][k*EntW +: EntW] <=
          {q_item.target_state, q_item.range_high, q_item.range_low};
      end
    end
    if (take && q_item.command == CMD_LOAD_ATTR && sidx_ok) begin
      attr_mem[q_item.state_index[RowW-1:0]] <= {q_item.fallback_state, q_item.accepting_flag};
    end
    row_q_r  <= row_mem[cur_r[RowW-1:0]];
    attr_q_r <= attr_mem[cur_r[RowW-1:0]];
    if (take) begin
      byte_r  <= q_item.data_byte;
      inrow_r <= cur_ok;
    end
  end

  always_comb begin
    logic [ByteW-1:0] lo, hi;
    hit    = 1'b0;
    hit_tg = '0;
    for (int k = 0; k < SLOTS_PER_STATE; k++) begin
      lo = row_q_r[k*EntW +: ByteW];
      hi = row_q_r[k*EntW + ByteW +: ByteW];
      if (lo == '0) lo = ByteW'(1);
      if (inrow_r && lo <= hi && byte_r >= lo && byte_r <= hi) begin
        hit    = 1'b1;
        hit_tg = row_q_r[k*EntW + 2*ByteW +: StateW];
      end
    end
  end

  assign pos_adv    = (pos_r == PosMax) ? PosMax : pos_r + POSITION_WIDTH'(1);
  assign sp_clamped = (POSITION_WIDTH >= 16) ? POSITION_WIDTH'(q_item.start_position) :
                      ((q_item.start_position > 16'(PosMax)) ? PosMax :
                       POSITION_WIDTH'(q_item.start_position));

  always_comb begin
    st_nxt  = st_r;
    cur_nxt = cur_r;
    pos_nxt = pos_r;
    act_nxt = act_r;
    emit    = 1'b0;
    emit_m  = 1'b0;
    emit_p  = pos_r;
    nxt_s   = '0;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          case (q_item.command)
            CMD_START: begin
              pos_nxt = sp_clamped;
              cur_nxt = entry_state;
              act_nxt = 1'b1;
              if (entry_state == error_state) begin
                emit    = 1'b1;
                emit_p  = sp_clamped;
                act_nxt = 1'b0;
              end
            end
            CMD_DATA: begin
              if (act_r) begin
                if (cur_r == error_state) begin
                  emit    = 1'b1;
                  act_nxt = 1'b0;
                end else begin
                  st_nxt = ST_EVAL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        st_nxt = ST_IDLE;
        if (!hit && byte_r == '0) begin
          emit    = 1'b1;
          emit_m  = inrow_r & attr_q_r[0];
          act_nxt = 1'b0;
        end else begin
          nxt_s   = hit ? hit_tg : (inrow_r ? attr_q_r[AttrW-1:1] : '0);
          cur_nxt = nxt_s;
          pos_nxt = pos_adv;
          if (nxt_s == error_state) begin
            emit    = 1'b1;
            emit_p  = pos_adv;
            act_nxt = 1'b0;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    om_nxt = om_r;
    op_nxt = op_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (emit) begin
      ov_nxt = 1'b1;
      om_nxt = emit_m;
      op_nxt = OutPosW'({{32{1'b0}}, emit_p});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cur_r <= '0;
      pos_r <= '0;
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cur_r <= cur_nxt;
      pos_r <= pos_nxt;
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    om_r <= om_nxt;
    op_r <= op_nxt;
  end

  assign out_valid        = ov_r;
  assign out_matched      = om_r;
  assign out_end_position = op_r;
endmodule

// ===== src/range_dfa_byte_matcher.sv =====
// Top level of the byte-range DFA matcher: stream ports, config registers.
// Instantiates rdbm_front and rdbm_back; uses rdbm_pkg.
//
// Input stream (in_*): one command per transfer: load slot, load state
// attributes, start, or data byte. Output stream (out_*): one result
// (matched, end_position) at the end of every match attempt.
// A two-entry queue decouples the slave port from the execution engine.
// Loads and start are handled in the engine's idle state; a data byte also
// passes through ST_EVAL (row read from the table memory, then range
// compares and state update), so the engine takes no new byte until the
// last one is evaluated. An input transfer is written into the queue,
// taken from it by the engine, and its result registered in the output
// register that drives out_tvalid; an evaluated data byte passes ST_EVAL first.
// While a result waits for out_tready, the engine holds; the queue keeps
// accepting until full, then in_tready drops.
// Reset clears the engine state, the queue and the output valid flag; the
// table memories stay undefined until loaded. Config registers take a write
// whenever cfg_we is high; write them only while the block is idle.
module range_dfa_byte_matcher
  import rdbm_pkg::*;
#(
  parameter int NUM_STATES      = NumStatesDef,
  parameter int SLOTS_PER_STATE = SlotsDef,
  parameter int POSITION_WIDTH  = PosWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // command, state_index, slot_index, range_low, range_high, target_state,
  // accepting_flag, fallback_state, start_position, data_byte
  input  logic [63:0]        in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // matched, end_position, pad
  output logic [23:0]        out_tdata,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [StateW-1:0]  cfg_data
);
  item_t              in_item, q_item;
  logic               q_valid, q_ready;
  logic [StateW-1:0]  entry_r, error_r;
  logic               m;
  logic [OutPosW-1:0] ep;

  assign in_item.command        = in_tdata[1:0];
  assign in_item.state_index    = in_tdata[7:2];
  assign in_item.slot_index     = in_tdata[10:8];
  assign in_item.range_low      = in_tdata[18:11];
  assign in_item.range_high     = in_tdata[26:19];
  assign in_item.target_state   = in_tdata[32:27];
  assign in_item.accepting_flag = in_tdata[33];
  assign in_item.fallback_state = in_tdata[39:34];
  assign in_item.start_position = in_tdata[55:40];
  assign in_item.data_byte      = in_tdata[63:56];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      error_r <= '1;
    end else if (cfg_we) begin
      if (cfg_index == REG_ENTRY) entry_r <= cfg_data;
      if (cfg_index == REG_ERROR) error_r <= cfg_data;
    end
  end

  rdbm_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  rdbm_back #(
    .NUM_STATES (NUM_STATES), .SLOTS_PER_STATE (SLOTS_PER_STATE),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .entry_state (entry_r), .error_state (error_r),
    .out_valid (out_tvalid), .out_ready (out_tready),
    .out_matched (m), .out_end_position (ep)
  );

  assign out_tdata = {7'd0, ep, m};
endmodule

// ===== src/rdbm_checker.sv =====
// Port-level checker for the DFA matcher, bound to the top level.
// Uses rdbm_pkg.
module rdbm_port_checker
  import rdbm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0)
    else $error("pad bits set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
  a_ready: assert property (@(posedge clk) $rose(rst_n) |-> in_tready)
    else $error("input not ready after reset");
endmodule

bind range_dfa_byte_matcher rdbm_port_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
